// ===== rtl/tfcs_pkg.sv =====
`timescale 1ns / 1ps
package tfcs_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_CYC1  = 3'd2,
    PH_CYC2  = 3'd3,
    PH_RINSE = 3'd4,
    PH_CYC3  = 3'd5,
    PH_END   = 3'd6
  } phase_t;

  localparam logic [15:0] TICKS_PER_SEC_RESET = 16'd1000;
  localparam logic [5:0]  SEC_MAX             = 6'd63;

  // Timing of the three flow/rest cycles, in seconds and rounds.
  localparam logic [5:0] CYC1_FLOW_S   = 6'd15;
  localparam logic [5:0] CYC1_REST_S   = 6'd30;
  localparam logic [3:0] CYC1_ROUNDS   = 4'd1;
  localparam logic [5:0] CYC23_FLOW_S  = 6'd5;
  localparam logic [5:0] CYC23_REST_S  = 6'd5;
  localparam logic [3:0] CYC2_ROUNDS   = 4'd5;
  localparam logic [3:0] CYC3_ROUNDS   = 4'd10;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] tick_count;
    logic [5:0]  second_count;
    logic [3:0]  round_count;
    logic        flow_on;
    logic        pump;
  } state_t;

  typedef struct packed {
    logic       busy_res;
    logic [2:0] phase;
    logic [1:0] cycle_number;
    logic [3:0] round_index;
    logic [5:0] elapsed_seconds;
    logic       pump_on;
  } result_t;

  typedef struct packed {
    logic [5:0] flow_s;
    logic [5:0] round_s;
    logic [3:0] rounds;
  } cycle_plan_t;

  function automatic cycle_plan_t cycle_plan(phase_t ph);
    cycle_plan_t p;
    p.flow_s  = CYC23_FLOW_S;
    p.round_s = 6'(CYC23_FLOW_S + CYC23_REST_S);
    p.rounds  = CYC3_ROUNDS;
    if (ph == PH_CYC1) begin
      p.flow_s  = CYC1_FLOW_S;
      p.round_s = 6'(CYC1_FLOW_S + CYC1_REST_S);
      p.rounds  = CYC1_ROUNDS;
    end else if (ph == PH_CYC2) begin
      p.rounds  = CYC2_ROUNDS;
    end
    return p;
  endfunction

endpackage

// ===== rtl/timed_flush_cycle_sequencer_unit.sv =====
`timescale 1ns / 1ps
// Backflush clean sequencer.
// Input channel (in_valid/in_ready): one transaction is one update carrying
// start_request, tick, button_pushed and paddle_on. Output channel
// (out_valid/out_ready): exactly one result transaction per update, with the
// phase, cycle number, round index, elapsed seconds and pump command.
// Configuration: cfg_we writes cfg_wdata into ticks_per_second; write only
// while no update is in flight.
// The result of an update is registered in the output register and offered
// in the cycle after the update is accepted. Throughput is one update per cycle
// while the receiver takes results, set by the single state register updated by one pass of the step logic.
// If the receiver stalls, the result waits in the output register and
// in_ready drops only while that register is full and not being taken; a
// transaction can be accepted in the same cycle the held result leaves.
// Reset puts the sequencer in the idle phase with counters cleared, flow
// state at rest, pump off, ticks_per_second at 1000 and no result pending.
module timed_flush_cycle_sequencer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        start_request,
  input  logic        tick,
  input  logic        button_pushed,
  input  logic        paddle_on,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        busy_res,
  output logic [2:0]  phase,
  output logic [1:0]  cycle_number,
  output logic [3:0]  round_index,
  output logic [5:0]  elapsed_seconds,
  output logic        pump_on
);
  import tfcs_pkg::*;

  logic [15:0] ticks_per_second;
  state_t      st;
  state_t      st_next;
  result_t     res_next;
  result_t     res_q;
  logic        accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= TICKS_PER_SEC_RESET;
    end else if (cfg_we) begin
      ticks_per_second <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase        <= PH_IDLE;
      st.tick_count   <= '0;
      st.second_count <= '0;
      st.round_count  <= '0;
      st.flow_on      <= 1'b0;
      st.pump         <= 1'b0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  tfcs_step u_step (
    .cur              (st),
    .ticks_per_second (ticks_per_second),
    .start_request    (start_request),
    .tick             (tick),
    .button_pushed    (button_pushed),
    .paddle_on        (paddle_on),
    .nxt              (st_next),
    .res              (res_next)
  );

  tfcs_out_reg u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (accept),
    .din   (res_next),
    .take  (out_ready),
    .valid (out_valid),
    .dout  (res_q)
  );

  assign busy_res        = res_q.busy_res;
  assign phase           = res_q.phase;
  assign cycle_number    = res_q.cycle_number;
  assign round_index     = res_q.round_index;
  assign elapsed_seconds = res_q.elapsed_seconds;
  assign pump_on         = res_q.pump_on;

  // Every accepted update produces a result in the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted update produced no result");

  // An accepted start request always reports the start phase with cleared counters.
  a_start_result: assert property (@(posedge clk) disable iff (rst)
    accept && start_request |=>
      phase == PH_START && round_index == 4'd0 && elapsed_seconds == 6'd0)
    else $error("start request did not restart the sequence");

  // While the flow state is flow, the pump must be driven.
  a_flow_drives_pump: assert property (@(posedge clk) disable iff (rst)
    st.flow_on |-> st.pump)
    else $error("flow state on with pump off");

  // The pump is never on while the sequencer is idle.
  a_idle_pump_off: assert property (@(posedge clk) disable iff (rst)
    st.phase == PH_IDLE |-> !st.pump && !st.flow_on)
    else $error("pump active in idle phase");

endmodule

// ===== rtl/tfcs_step.sv =====
`timescale 1ns / 1ps
module tfcs_step (
  input  tfcs_pkg::state_t  cur,
  input  logic [15:0]       ticks_per_second,
  input  logic              start_request,
  input  logic              tick,
  input  logic              button_pushed,
  input  logic              paddle_on,
  output tfcs_pkg::state_t  nxt,
  output tfcs_pkg::result_t res
);
  import tfcs_pkg::*;

  always_comb begin
    state_t      s;
    phase_t      ph;
    logic [15:0] tc_inc;
    logic [3:0]  rnd;
    logic        adv;
    logic        fl_en;
    logic        fl_val;
    cycle_plan_t cp;

    s      = cur;
    ph     = cur.phase;
    tc_inc = 16'(cur.tick_count + 16'd1);
    rnd    = 4'(cur.round_count + 4'd1);
    adv    = 1'b0;
    fl_en  = 1'b0;
    fl_val = 1'b0;
    cp     = cycle_plan(cur.phase);

    if (start_request) begin
      s.phase        = PH_START;
      s.tick_count   = '0;
      s.second_count = '0;
      s.round_count  = '0;
      fl_en          = 1'b1;
    end else begin
      if (tick) begin
        // A register value of zero behaves like one: every tick wraps.
        if (tc_inc >= ticks_per_second) begin
          s.tick_count = '0;
          if (cur.second_count < SEC_MAX) begin
            s.second_count = 6'(cur.second_count + 6'd1);
          end
        end else begin
          s.tick_count = tc_inc;
        end
      end

      if (button_pushed && ph != PH_RINSE && ph != PH_IDLE) begin
        ph = PH_END;
      end
      s.phase = ph;

      unique case (ph)
        PH_START: begin
          adv = 1'b1;
        end
        PH_CYC1, PH_CYC2, PH_CYC3: begin
          if (s.second_count >= cp.round_s) begin
            s.round_count = rnd;
            if (rnd >= cp.rounds) begin
              adv = 1'b1;
            end else begin
              s.tick_count   = '0;
              s.second_count = '0;
              fl_en          = 1'b1;
              fl_val         = 1'b1;
            end
          end else if (s.second_count >= cp.flow_s) begin
            fl_en = 1'b1;
          end
        end
        PH_RINSE: begin
          s.pump = paddle_on;
          if (!paddle_on && button_pushed) begin
            adv = 1'b1;
          end
        end
        PH_END: begin
          fl_en = 1'b1;
        end
        default: begin
        end
      endcase

      if (adv) begin
        s.phase        = phase_t'(3'(ph + 3'd1));
        s.tick_count   = '0;
        s.second_count = '0;
        s.round_count  = '0;
        fl_en          = 1'b1;
        fl_val         = (s.phase == PH_CYC1) || (s.phase == PH_CYC2) ||
                         (s.phase == PH_CYC3);
      end
    end

    // The pump only follows the flow state when the flow state changes.
    if (fl_en) begin
      if (fl_val != s.flow_on) begin
        s.pump = fl_val;
      end
      s.flow_on = fl_val;
    end

    nxt = s;
  end

  always_comb begin
    res.busy_res        = (nxt.phase >= PH_START) && (nxt.phase <= PH_CYC3);
    res.phase           = nxt.phase;
    res.round_index     = nxt.round_count;
    res.elapsed_seconds = nxt.second_count;
    res.pump_on         = nxt.pump;
    unique case (nxt.phase)
      PH_CYC1: res.cycle_number = 2'd1;
      PH_CYC2: res.cycle_number = 2'd2;
      PH_CYC3: res.cycle_number = 2'd3;
      default: res.cycle_number = 2'd0;
    endcase
  end

endmodule

// ===== rtl/tfcs_out_reg.sv =====
`timescale 1ns / 1ps
module tfcs_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  tfcs_pkg::result_t din,
  input  logic              take,
  output logic              valid,
  output tfcs_pkg::result_t dout
);
  import tfcs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

endmodule
